### hdl/vbag_pkg.sv
package vbag_pkg;

    localparam int DIM_BITS   = 16;
    localparam int IDX_W      = 48;
    localparam int BUDGET_W   = 48;
    localparam int PLANE_W    = 2 * DIM_BITS;
    localparam int TOTAL_W    = 3 * DIM_BITS;
    localparam int CMP_W      = (TOTAL_W > IDX_W) ? TOTAL_W : IDX_W;
    localparam int DIV_CNT_W  = $clog2(IDX_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BUDGET_W;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_DIM_Z  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_DIM_Y  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_DIM_X  = cfg_idx_t'(2);
    localparam cfg_idx_t REG_BUDGET = cfg_idx_t'(3);

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_SLAB = 2'd0;
    localparam mode_t MODE_ROW  = 2'd1;
    localparam mode_t MODE_RUN  = 2'd2;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE        = 5'd0;
    localparam op_t OP_DIV_PLANE   = 5'd1;
    localparam op_t OP_SET_SLAB    = 5'd2;
    localparam op_t OP_DIV_ROW     = 5'd3;
    localparam op_t OP_SET_ROW_RUN = 5'd4;
    localparam op_t OP_DIV_COUNT   = 5'd5;
    localparam op_t OP_SET_COUNT   = 5'd6;
    localparam op_t OP_TOTAL_A     = 5'd7;
    localparam op_t OP_TOTAL_B     = 5'd8;
    localparam op_t OP_SEEK_SLAB   = 5'd9;
    localparam op_t OP_DIV_K       = 5'd10;
    localparam op_t OP_SEEK_ROW    = 5'd11;
    localparam op_t OP_DIV_ROWIDX  = 5'd12;
    localparam op_t OP_SEEK_RUN    = 5'd13;
    localparam op_t OP_STEP        = 5'd14;
    localparam op_t OP_SPAN        = 5'd15;
    localparam op_t OP_MUL         = 5'd16;
    localparam op_t OP_FINISH      = 5'd17;
    localparam op_t OP_ERROR       = 5'd18;

    typedef struct packed {
        logic load_index;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic  div_busy;
        logic  quo_zero;
        logic  need_restart;
        logic  idx_over;
        logic  idx_same;
        logic  idx_next;
        logic  out_free;
        mode_t mode;
    } status_t;

endpackage

### hdl/vbag_divider.sv
module vbag_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [vbag_pkg::IDX_W-1:0]    dividend,
    input  logic [vbag_pkg::PLANE_W-1:0]  divisor,
    output logic                          busy,
    output logic [vbag_pkg::IDX_W-1:0]    quotient,
    output logic [vbag_pkg::PLANE_W-1:0]  remainder
);

    localparam int QW   = vbag_pkg::IDX_W;
    localparam int RW   = vbag_pkg::PLANE_W;
    localparam int CNTW = vbag_pkg::DIV_CNT_W;

    logic [CNTW-1:0] cnt_reg;
    logic [QW-1:0]   quo_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   dvs_reg;
    logic [RW:0]     trial;
    logic            fits;
    logic [RW-1:0]   rem_next;

    // restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[QW-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? RW'(trial - {1'b0, dvs_reg}) : trial[RW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNTW'(QW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[QW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hdl/vbag_datapath.sv
module vbag_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  vbag_pkg::cmd_t                   cmd,
    output vbag_pkg::status_t                status,
    input  logic [vbag_pkg::IDX_W-1:0]       s_block_index,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vbag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vbag_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_start_z,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_start_y,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_start_x,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_span_z,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_span_y,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_span_x,
    output logic [vbag_pkg::IDX_W-1:0]       m_block_elements,
    output logic                             m_index_error
);

    localparam int DW = vbag_pkg::DIM_BITS;
    localparam int IW = vbag_pkg::IDX_W;
    localparam int BW = vbag_pkg::BUDGET_W;
    localparam int PW = vbag_pkg::PLANE_W;
    localparam int TW = vbag_pkg::TOTAL_W;
    localparam int CW = vbag_pkg::CMP_W;

    function automatic logic [DW-1:0] span_len(input logic [DW-1:0] d,
                                               input logic [DW-1:0] p,
                                               input logic [DW-1:0] n);
        logic [DW-1:0] rest;
        rest = d - p;
        return (rest > n) ? n : rest;
    endfunction

    // configuration
    logic [DW-1:0] dim_z_reg, dim_y_reg, dim_x_reg;
    logic [BW-1:0] budget_reg;
    logic          need_restart_reg;
    logic [DW-1:0] dz, dy, dx;
    logic [IW-1:0] budget_eff;
    logic [PW-1:0] plane;

    // tiling
    vbag_pkg::mode_t mode_reg;
    logic [DW-1:0] nom_z_reg, nom_y_reg, nom_x_reg;
    logic [DW-1:0] count_reg;
    logic [TW-1:0] total_reg;
    logic [PW-1:0] total_a;
    logic [TW-1:0] total_run;

    // walker
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] cur_block_reg, next_block_reg;
    logic [DW-1:0] pos_z_reg, pos_y_reg, pos_x_reg;
    logic [DW-1:0] step_z, step_y, step_x;
    logic [DW:0]   y_add, x_add;
    logic [DW-1:0] seek_a, seek_b;
    logic [PW-1:0] seek_prod;

    // block size
    logic [DW-1:0] span_z_reg, span_y_reg, span_x_reg;
    logic [PW-1:0] prod_reg;
    logic [TW-1:0] elem_full;

    // result register
    logic          m_valid_reg;
    logic [DW-1:0] out_start_z_reg, out_start_y_reg, out_start_x_reg;
    logic [DW-1:0] out_span_z_reg, out_span_y_reg, out_span_x_reg;
    logic [IW-1:0] out_elems_reg;
    logic          out_err_reg;
    logic          out_free;

    // divider
    logic          div_start;
    logic [IW-1:0] div_dvd;
    logic [PW-1:0] div_dvs;
    logic          div_busy;
    logic [IW-1:0] div_quo;
    logic [PW-1:0] div_rem;

    assign cfg_ready = 1'b1;

    assign dz         = (dim_z_reg == '0) ? DW'(1) : dim_z_reg;
    assign dy         = (dim_y_reg == '0) ? DW'(1) : dim_y_reg;
    assign dx         = (dim_x_reg == '0) ? DW'(1) : dim_x_reg;
    assign budget_eff = (budget_reg == '0) ? IW'(1) : IW'(budget_reg);
    assign plane      = PW'(dx) * PW'(dy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_z_reg  <= DW'(1);
            dim_y_reg  <= DW'(1);
            dim_x_reg  <= DW'(1);
            budget_reg <= BW'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vbag_pkg::REG_DIM_Z:  dim_z_reg  <= cfg_data[DW-1:0];
                vbag_pkg::REG_DIM_Y:  dim_y_reg  <= cfg_data[DW-1:0];
                vbag_pkg::REG_DIM_X:  dim_x_reg  <= cfg_data[DW-1:0];
                vbag_pkg::REG_BUDGET: budget_reg <= cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_restart_reg <= 1'b1;
        end else if (cfg_valid && cfg_index <= vbag_pkg::REG_BUDGET) begin
            need_restart_reg <= 1'b1;
        end else if (cmd.op == vbag_pkg::OP_TOTAL_B) begin
            need_restart_reg <= 1'b0;
        end
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_dvd   = budget_eff;
        div_dvs   = plane;
        unique case (cmd.op)
            vbag_pkg::OP_DIV_PLANE: begin
                div_start = 1'b1;
            end
            vbag_pkg::OP_DIV_ROW: begin
                div_start = 1'b1;
                div_dvs   = PW'(dx);
            end
            vbag_pkg::OP_DIV_COUNT: begin
                div_start = 1'b1;
                unique case (mode_reg)
                    vbag_pkg::MODE_SLAB: begin
                        div_dvd = IW'(dz);
                        div_dvs = PW'(nom_z_reg);
                    end
                    vbag_pkg::MODE_ROW: begin
                        div_dvd = IW'(dy);
                        div_dvs = PW'(nom_y_reg);
                    end
                    default: begin
                        div_dvd = IW'(dx);
                        div_dvs = PW'(nom_x_reg);
                    end
                endcase
            end
            vbag_pkg::OP_DIV_K: begin
                div_start = 1'b1;
                div_dvd   = idx_reg;
                div_dvs   = PW'(count_reg);
            end
            vbag_pkg::OP_DIV_ROWIDX: begin
                div_start = 1'b1;
                div_dvd   = div_quo;
                div_dvs   = PW'(dy);
            end
            default: ;
        endcase
    end

    vbag_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // tiling mode, nominal block, block count
    assign total_a   = (mode_reg == vbag_pkg::MODE_SLAB) ? PW'(count_reg)
                                                         : PW'(dz) * PW'(count_reg);
    assign total_run = TW'(total_reg[PW-1:0]) * TW'(dy);

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            vbag_pkg::OP_SET_SLAB: begin
                mode_reg  <= vbag_pkg::MODE_SLAB;
                nom_z_reg <= (div_quo > IW'(dz)) ? dz : div_quo[DW-1:0];
                nom_y_reg <= dy;
                nom_x_reg <= dx;
            end
            vbag_pkg::OP_SET_ROW_RUN: begin
                nom_z_reg <= DW'(1);
                if (div_quo != '0) begin
                    mode_reg  <= vbag_pkg::MODE_ROW;
                    nom_y_reg <= div_quo[DW-1:0];
                    nom_x_reg <= dx;
                end else begin
                    mode_reg  <= vbag_pkg::MODE_RUN;
                    nom_y_reg <= DW'(1);
                    nom_x_reg <= budget_eff[DW-1:0];
                end
            end
            vbag_pkg::OP_SET_COUNT: begin
                count_reg <= div_quo[DW-1:0] + DW'(div_rem != '0);
            end
            vbag_pkg::OP_TOTAL_A: begin
                total_reg <= TW'(total_a);
            end
            vbag_pkg::OP_TOTAL_B: begin
                if (mode_reg == vbag_pkg::MODE_RUN) begin
                    total_reg <= total_run;
                end
            end
            default: ;
        endcase
    end

    // walker
    assign y_add = {1'b0, pos_y_reg}
                 + {1'b0, (mode_reg == vbag_pkg::MODE_ROW) ? nom_y_reg : DW'(1)};
    assign x_add = {1'b0, pos_x_reg} + {1'b0, nom_x_reg};

    always_comb begin
        step_z = pos_z_reg;
        step_y = pos_y_reg;
        step_x = pos_x_reg;
        unique case (mode_reg)
            vbag_pkg::MODE_SLAB: begin
                step_z = pos_z_reg + nom_z_reg;
            end
            vbag_pkg::MODE_ROW: begin
                if (y_add >= {1'b0, dy}) begin
                    step_y = '0;
                    step_z = pos_z_reg + DW'(1);
                end else begin
                    step_y = y_add[DW-1:0];
                end
            end
            default: begin
                if (x_add >= {1'b0, dx}) begin
                    step_x = '0;
                    if (y_add >= {1'b0, dy}) begin
                        step_y = '0;
                        step_z = pos_z_reg + DW'(1);
                    end else begin
                        step_y = y_add[DW-1:0];
                    end
                end else begin
                    step_x = x_add[DW-1:0];
                end
            end
        endcase
    end

    // one multiplier for all seek offsets
    always_comb begin
        seek_a = div_rem[DW-1:0];
        seek_b = nom_x_reg;
        unique case (mode_reg)
            vbag_pkg::MODE_SLAB: begin
                seek_a = idx_reg[DW-1:0];
                seek_b = nom_z_reg;
            end
            vbag_pkg::MODE_ROW: begin
                seek_b = nom_y_reg;
            end
            default: ;
        endcase
    end

    assign seek_prod = PW'(seek_a) * PW'(seek_b);

    always_ff @(posedge aclk) begin
        if (cmd.load_index) begin
            idx_reg <= s_block_index;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            vbag_pkg::OP_TOTAL_B: begin
                pos_z_reg      <= '0;
                pos_y_reg      <= '0;
                pos_x_reg      <= '0;
                cur_block_reg  <= '0;
                next_block_reg <= IW'(1);
            end
            vbag_pkg::OP_SEEK_SLAB: begin
                pos_z_reg <= seek_prod[DW-1:0];
                pos_y_reg <= '0;
                pos_x_reg <= '0;
            end
            vbag_pkg::OP_SEEK_ROW: begin
                pos_z_reg <= div_quo[DW-1:0];
                pos_y_reg <= seek_prod[DW-1:0];
                pos_x_reg <= '0;
            end
            vbag_pkg::OP_DIV_ROWIDX: begin
                pos_x_reg <= seek_prod[DW-1:0];
            end
            vbag_pkg::OP_SEEK_RUN: begin
                pos_z_reg <= div_quo[DW-1:0];
                pos_y_reg <= div_rem[DW-1:0];
            end
            vbag_pkg::OP_STEP: begin
                pos_z_reg <= step_z;
                pos_y_reg <= step_y;
                pos_x_reg <= step_x;
            end
            vbag_pkg::OP_SPAN: begin
                cur_block_reg  <= idx_reg;
                next_block_reg <= idx_reg + IW'(1);
            end
            default: ;
        endcase
    end

    // spans and element count
    assign elem_full = TW'(prod_reg) * TW'(span_x_reg);

    always_ff @(posedge aclk) begin
        if (cmd.op == vbag_pkg::OP_SPAN) begin
            span_z_reg <= span_len(dz, pos_z_reg, nom_z_reg);
            span_y_reg <= span_len(dy, pos_y_reg, nom_y_reg);
            span_x_reg <= span_len(dx, pos_x_reg, nom_x_reg);
        end
        if (cmd.op == vbag_pkg::OP_MUL) begin
            prod_reg <= PW'(span_z_reg) * PW'(span_y_reg);
        end
    end

    // result register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == vbag_pkg::OP_FINISH || cmd.op == vbag_pkg::OP_ERROR) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == vbag_pkg::OP_FINISH) begin
            out_start_z_reg <= pos_z_reg;
            out_start_y_reg <= pos_y_reg;
            out_start_x_reg <= pos_x_reg;
            out_span_z_reg  <= span_z_reg;
            out_span_y_reg  <= span_y_reg;
            out_span_x_reg  <= span_x_reg;
            out_elems_reg   <= IW'(elem_full);
            out_err_reg     <= 1'b0;
        end else if (cmd.op == vbag_pkg::OP_ERROR) begin
            out_start_z_reg <= '0;
            out_start_y_reg <= '0;
            out_start_x_reg <= '0;
            out_span_z_reg  <= '0;
            out_span_y_reg  <= '0;
            out_span_x_reg  <= '0;
            out_elems_reg   <= '0;
            out_err_reg     <= 1'b1;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_start_z        = out_start_z_reg;
    assign m_start_y        = out_start_y_reg;
    assign m_start_x        = out_start_x_reg;
    assign m_span_z         = out_span_z_reg;
    assign m_span_y         = out_span_y_reg;
    assign m_span_x         = out_span_x_reg;
    assign m_block_elements = out_elems_reg;
    assign m_index_error    = out_err_reg;

    // status to controller
    assign status.div_busy     = div_busy;
    assign status.quo_zero     = div_quo == '0;
    assign status.need_restart = need_restart_reg;
    assign status.idx_over     = CW'(idx_reg) >= CW'(total_reg);
    assign status.idx_same     = idx_reg == cur_block_reg;
    assign status.idx_next     = idx_reg == next_block_reg;
    assign status.out_free     = out_free;
    assign status.mode         = mode_reg;

endmodule

### hdl/vbag_ctrl.sv
module vbag_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vbag_pkg::status_t status,
    output vbag_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_W_PLANE = 4'd2;
    localparam logic [3:0] S_W_ROW   = 4'd3;
    localparam logic [3:0] S_COUNT   = 4'd4;
    localparam logic [3:0] S_W_COUNT = 4'd5;
    localparam logic [3:0] S_TOTAL_A = 4'd6;
    localparam logic [3:0] S_TOTAL_B = 4'd7;
    localparam logic [3:0] S_W_K     = 4'd8;
    localparam logic [3:0] S_W_RI    = 4'd9;
    localparam logic [3:0] S_SPAN    = 4'd10;
    localparam logic [3:0] S_MUL     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;
    localparam logic [3:0] S_ERR     = 4'd13;

    logic [3:0]      state_reg, state_next;
    vbag_pkg::op_t   op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = vbag_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (status.need_restart) begin
                    op         = vbag_pkg::OP_DIV_PLANE;
                    state_next = S_W_PLANE;
                end else if (status.idx_over) begin
                    state_next = S_ERR;
                end else if (status.idx_same) begin
                    op         = vbag_pkg::OP_SPAN;
                    state_next = S_MUL;
                end else if (status.idx_next) begin
                    op         = vbag_pkg::OP_STEP;
                    state_next = S_SPAN;
                end else if (status.mode == vbag_pkg::MODE_SLAB) begin
                    op         = vbag_pkg::OP_SEEK_SLAB;
                    state_next = S_SPAN;
                end else begin
                    op         = vbag_pkg::OP_DIV_K;
                    state_next = S_W_K;
                end
            end
            S_W_PLANE: begin
                if (!status.div_busy) begin
                    if (status.quo_zero) begin
                        op         = vbag_pkg::OP_DIV_ROW;
                        state_next = S_W_ROW;
                    end else begin
                        op         = vbag_pkg::OP_SET_SLAB;
                        state_next = S_COUNT;
                    end
                end
            end
            S_W_ROW: begin
                if (!status.div_busy) begin
                    op         = vbag_pkg::OP_SET_ROW_RUN;
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                op         = vbag_pkg::OP_DIV_COUNT;
                state_next = S_W_COUNT;
            end
            S_W_COUNT: begin
                if (!status.div_busy) begin
                    op         = vbag_pkg::OP_SET_COUNT;
                    state_next = S_TOTAL_A;
                end
            end
            S_TOTAL_A: begin
                op         = vbag_pkg::OP_TOTAL_A;
                state_next = S_TOTAL_B;
            end
            S_TOTAL_B: begin
                op         = vbag_pkg::OP_TOTAL_B;
                state_next = S_CHECK;
            end
            S_W_K: begin
                if (!status.div_busy) begin
                    if (status.mode == vbag_pkg::MODE_ROW) begin
                        op         = vbag_pkg::OP_SEEK_ROW;
                        state_next = S_SPAN;
                    end else begin
                        op         = vbag_pkg::OP_DIV_ROWIDX;
                        state_next = S_W_RI;
                    end
                end
            end
            S_W_RI: begin
                if (!status.div_busy) begin
                    op         = vbag_pkg::OP_SEEK_RUN;
                    state_next = S_SPAN;
                end
            end
            S_SPAN: begin
                op         = vbag_pkg::OP_SPAN;
                state_next = S_MUL;
            end
            S_MUL: begin
                op         = vbag_pkg::OP_MUL;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (status.out_free) begin
                    op         = vbag_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            S_ERR: begin
                if (status.out_free) begin
                    op         = vbag_pkg::OP_ERROR;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready        = state_reg == S_IDLE;
    assign cmd.load_index = s_valid && s_ready;
    assign cmd.op         = op;

endmodule

### hdl/volume_block_address_generator.sv
// result path: the next block in order steps the position, a repeat of the current block
// reuses it, a slab seek multiplies the index, and a row seek or a run seek takes one or two
// passes of the radix-2 divider; each then computes spans and the element count
// throughput: one transaction at a time, taken in idle once the prior result is registered;
// the first after a config write adds a restart: 2 divider passes in slab tiling, else 3
// reset: synchronous active-low aresetn; registers read 1, restart pending, no result held
module volume_block_address_generator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [vbag_pkg::IDX_W-1:0]       s_block_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_start_z,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_start_y,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_start_x,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_span_z,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_span_y,
    output logic [vbag_pkg::DIM_BITS-1:0]    m_span_x,
    output logic [vbag_pkg::IDX_W-1:0]       m_block_elements,
    output logic                             m_index_error,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vbag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vbag_pkg::CFG_DATA_W-1:0]  cfg_data
);

    vbag_pkg::cmd_t    cmd;
    vbag_pkg::status_t status;

    vbag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vbag_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_block_index    (s_block_index),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_z        (m_start_z),
        .m_start_y        (m_start_y),
        .m_start_x        (m_start_x),
        .m_span_z         (m_span_z),
        .m_span_y         (m_span_y),
        .m_span_x         (m_span_x),
        .m_block_elements (m_block_elements),
        .m_index_error    (m_index_error)
    );

endmodule
